>>> design/ttx_pkg.sv
// ----------------------------------------------------------------------------
// ttx_pkg
// shared types, sizes and the byte classifier of the text term extractor
// ----------------------------------------------------------------------------
package ttx_pkg;

	// bytes that may wait for a decision
	localparam int unsigned DEPTH  = 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W  = $clog2(DEPTH);
	// results of one request: the waiting bytes, the byte itself, a separator
	localparam int unsigned STEP_W = $clog2(DEPTH + 3);
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FPTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_ALNUM = 2'd1,
		CLS_PUNCT = 2'd2,
		CLS_HIGH  = 2'd3
	} byte_class_t;

	// work handed from the front to the back for one request
	typedef struct packed {
		logic [CNT_W-1:0] flush_n;   // waiting bytes to emit first
		logic             emit;      // emit the request byte
		logic             sep;       // close the term afterwards
		logic             push;      // park the byte in the store
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       data;
	} cmd_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		c = CLS_OTHER;
		if (b[7]) begin
			c = CLS_HIGH;
		end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
			c = CLS_ALNUM;
		end else if (b inside {8'h21, [8'h23:8'h27], [8'h2A:8'h2C], 8'h2E, 8'h2F,
				8'h3A, 8'h3D, 8'h3F, 8'h40, 8'h5C, [8'h5E:8'h60], 8'h7C}) begin
			c = CLS_PUNCT;
		end
		return c;
	endfunction

endpackage

>>> design/ttx_front.sv
// ----------------------------------------------------------------------------
// ttx_front
// classifies each text byte and decides what the back has to emit
// ----------------------------------------------------------------------------
module ttx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_eos,
	input  logic              fifo_full,
	output logic              cmd_valid,
	output ttx_pkg::cmd_t     cmd
);

	localparam int unsigned CNT_W = ttx_pkg::CNT_W;
	localparam int unsigned IDX_W = ttx_pkg::IDX_W;

	logic [CNT_W-1:0]     pcnt_q, ppcnt_q, n_pcnt, n_ppcnt;
	ttx_pkg::byte_class_t prev_q, n_prev, cls;
	logic                 term_q, n_term, skip_q, n_skip, skip, store_full, accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;
	assign cls      = ttx_pkg::classify(in_byte);
	assign skip     = skip_q && (cls == prev_q);
	assign store_full = pcnt_q >= CNT_W'(ttx_pkg::DEPTH);

	always_comb begin
		cmd         = '0;
		cmd.data    = in_byte;
		cmd.wr_idx  = pcnt_q[IDX_W-1:0];
		n_pcnt      = pcnt_q;
		n_ppcnt     = ppcnt_q;
		n_term      = term_q;
		n_skip      = skip_q;
		if (!skip) begin
			n_skip = 1'b0;
			case (cls)
				ttx_pkg::CLS_ALNUM: begin
					cmd.flush_n = pcnt_q;
					cmd.emit    = 1'b1;
					n_pcnt      = '0;
					n_ppcnt     = '0;
					n_term      = 1'b1;
				end
				ttx_pkg::CLS_HIGH: begin
					if (term_q && pcnt_q == '0) begin
						cmd.emit = 1'b1;
					end else if (store_full) begin
						// overflow: drop what waits and skip the rest of the run
						n_pcnt  = '0;
						n_ppcnt = '0;
						cmd.sep = term_q;
						n_term  = 1'b0;
						n_skip  = 1'b1;
					end else begin
						cmd.push = 1'b1;
						n_pcnt   = pcnt_q + 1'b1;
					end
				end
				ttx_pkg::CLS_PUNCT: begin
					if (term_q && pcnt_q == ppcnt_q) begin
						if (store_full) begin
							n_pcnt  = '0;
							n_ppcnt = '0;
							cmd.sep = 1'b1;
							n_term  = 1'b0;
							n_skip  = 1'b1;
						end else begin
							cmd.push = 1'b1;
							n_pcnt   = pcnt_q + 1'b1;
							n_ppcnt  = ppcnt_q + 1'b1;
						end
					end else begin
						// punct after a high run, or outside a term
						n_pcnt  = '0;
						n_ppcnt = '0;
						cmd.sep = term_q;
						n_term  = 1'b0;
					end
				end
				default: begin
					n_pcnt  = '0;
					n_ppcnt = '0;
					cmd.sep = term_q;
					n_term  = 1'b0;
				end
			endcase
		end
		n_prev = cls;
		if (in_eos) begin
			cmd.sep = cmd.sep || n_term;
			n_term  = 1'b0;
			n_pcnt  = '0;
			n_ppcnt = '0;
			n_prev  = ttx_pkg::CLS_OTHER;
			n_skip  = 1'b0;
		end
	end

	assign cmd_valid = accept && (cmd.push || cmd.emit || cmd.sep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q  <= '0;
			ppcnt_q <= '0;
			prev_q  <= ttx_pkg::CLS_OTHER;
			term_q  <= 1'b0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			pcnt_q  <= n_pcnt;
			ppcnt_q <= n_ppcnt;
			prev_q  <= n_prev;
			term_q  <= n_term;
			skip_q  <= n_skip;
		end
	end

	a_punct_leads: assert property (@(posedge clk) disable iff (!arst_n)
		ppcnt_q <= pcnt_q && pcnt_q <= CNT_W'(ttx_pkg::DEPTH))
		else $error("pending counts out of range");

endmodule

>>> design/ttx_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ttx_cmd_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module ttx_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ttx_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          head_valid,
	output ttx_pkg::cmd_t head
);

	localparam int unsigned FPTR_W = ttx_pkg::FPTR_W;
	localparam int unsigned FCNT_W = ttx_pkg::FCNT_W;

	ttx_pkg::cmd_t     slot_q [ttx_pkg::FIFO_DEPTH];
	logic [FPTR_W-1:0] wptr_q, rptr_q;
	logic [FCNT_W-1:0] cnt_q;

	assign full       = cnt_q == FCNT_W'(ttx_pkg::FIFO_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FCNT_W'(wr_en) - FCNT_W'(rd_en);
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head_valid)
		else $error("request queue read while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("request queue written while full");

endmodule

>>> design/ttx_back.sv
// ----------------------------------------------------------------------------
// ttx_back
// carries out requests: pending store, result sequencer and output register
// ----------------------------------------------------------------------------
module ttx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ttx_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_sep,
	output logic          out_last
);

	localparam int unsigned IDX_W  = ttx_pkg::IDX_W;
	localparam int unsigned STEP_W = ttx_pkg::STEP_W;

	logic [7:0]        store_q [ttx_pkg::DEPTH];
	logic [7:0]        rd_data_q;
	logic [STEP_W-1:0] step_q, total, flush_n;
	logic              is_mem, is_byte, is_last, has_res;
	logic              s1_load, s1_ready, out_adv;
	logic              valid_s1, mem_s1, sep_s1, last_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q, out_sep_q, out_last_q;
	logic [7:0]        out_byte_q;

	assign flush_n = STEP_W'(head.flush_n);
	assign total   = flush_n + STEP_W'(head.emit) + STEP_W'(head.sep);
	assign has_res = total != '0;
	assign is_mem  = step_q < flush_n;
	assign is_byte = !is_mem && head.emit && step_q == flush_n;
	assign is_last = step_q == total - 1'b1;

	assign out_adv  = !out_valid_q || out_ready;
	assign s1_ready = !valid_s1 || out_adv;
	assign s1_load  = head_valid && has_res && s1_ready;
	assign pop      = head_valid && (!has_res || (s1_load && is_last));

	// store writes and reads never meet in one request
	always_ff @(posedge clk) begin
		if (pop && head.push) begin
			store_q[head.wr_idx] <= head.data;
		end
		if (s1_load && is_mem) begin
			rd_data_q <= store_q[step_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			mem_s1  <= is_mem;
			sep_s1  <= !is_mem && !is_byte;
			last_s1 <= is_last;
			byte_s1 <= is_byte ? head.data : 8'h00;
		end
		if (out_adv && valid_s1) begin
			out_byte_q <= mem_s1 ? rd_data_q : byte_s1;
			out_sep_q  <= sep_s1;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= '0;
			end else if (s1_load) begin
				step_q <= step_q + 1'b1;
			end
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_sep   = out_sep_q;
	assign out_last  = out_last_q;

	a_read_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_load && is_mem) |-> step_q < STEP_W'(ttx_pkg::DEPTH))
		else $error("pending store read beyond its depth");

	a_step_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && has_res) |-> step_q < total)
		else $error("result step passed the end of its request");

endmodule

>>> design/text_term_extractor_unit.sv
// ----------------------------------------------------------------------------
// text_term_extractor_unit
// streaming term extractor: text bytes in, term bytes and separators out
// ----------------------------------------------------------------------------
// s_* carries one text byte per request, s_tlast marks the end of the stream.
// m_* carries the results: a term byte, or a separator (m_tuser high) that
// closes a term; m_tlast marks the final result caused by one input byte.
// Each byte gives zero to 34 results in input order.
// The front classifies a byte in the cycle it is taken and writes a request
// into a four-entry queue; the back turns each request into results, one per
// cycle when m_tready allows, through a store read stage and output register.
// Input throughput is one byte per cycle while the queue has room; a byte that
// releases n waiting bytes makes n + 1 or n + 2 results, so long pending
// flushes stall the input once the queue fills.
// The first result of a byte passes the request queue, the store read stage
// and the output register before it is offered on m_*.
// After reset no term is open and nothing waits. A stalled m_tready holds the
// output register; the queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
module text_term_extractor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tuser,   // is_separator
	output logic       m_tlast    // last_result
);

	ttx_pkg::cmd_t wr_cmd, head;
	logic          wr_en, full, head_valid, pop;

	ttx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_eos    (s_tlast),
		.fifo_full (full),
		.cmd_valid (wr_en),
		.cmd       (wr_cmd)
	);

	ttx_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_cmd     (wr_cmd),
		.full       (full),
		.rd_en      (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ttx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_sep    (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

>>> test/text_term_extractor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_term_extractor_checker
// watches both streams of the term extractor, predicts the results of each
// accepted text byte and compares them in order with what comes out
// ----------------------------------------------------------------------------
module text_term_extractor_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_stream
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // out_byte
	input  logic       m_tuser,   // is_separator
	input  logic       m_tlast,   // last_result
	output int         errors,
	output int         awaited
);

	typedef struct {
		logic [7:0] data;
		logic       sep;
		logic       last;
	} term_result_t;

	term_result_t awaited_results[$];
	term_result_t byte_results[$];

	// bytes whose fate is still open
	logic [7:0]           held_bytes [ttx_pkg::DEPTH];
	int unsigned          held_n;
	int unsigned          held_punct_n;
	ttx_pkg::byte_class_t last_cls;
	logic                 in_term;
	logic                 discarding;

	function automatic ttx_pkg::byte_class_t class_of(input logic [7:0] b);
		ttx_pkg::byte_class_t c;
		if (b[7]) begin
			c = ttx_pkg::CLS_HIGH;
		end else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
				(b >= 8'h61 && b <= 8'h7A)) begin
			c = ttx_pkg::CLS_ALNUM;
		end else begin
			case (b)
				8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2C,
				8'h2E, 8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h40, 8'h5C, 8'h5E, 8'h5F,
				8'h60, 8'h7C: c = ttx_pkg::CLS_PUNCT;
				default: c = ttx_pkg::CLS_OTHER;
			endcase
		end
		return c;
	endfunction

	task automatic put_result(input logic [7:0] d, input logic sep);
		term_result_t r;
		r.data = sep ? 8'h00 : d;
		r.sep  = sep;
		r.last = 1'b0;
		byte_results.push_back(r);
	endtask

	task automatic end_term();
		held_n       = 0;
		held_punct_n = 0;
		if (in_term) put_result(8'h00, 1'b1);
		in_term = 1'b0;
	endtask

	task automatic hold_byte(input logic [7:0] b, input logic punct);
		if (held_n >= ttx_pkg::DEPTH) begin
			// store full: drop everything and skip the rest of this run
			end_term();
			discarding = 1'b1;
		end else begin
			held_bytes[held_n] = b;
			held_n++;
			if (punct) held_punct_n++;
		end
	endtask

	task automatic predict_terms(input logic [7:0] b, input logic eos);
		ttx_pkg::byte_class_t c;
		c = class_of(b);
		byte_results.delete();
		if (!(discarding && c == last_cls)) begin
			discarding = 1'b0;
			case (c)
				ttx_pkg::CLS_ALNUM: begin
					for (int i = 0; i < held_n; i++) put_result(held_bytes[i], 1'b0);
					held_n       = 0;
					held_punct_n = 0;
					put_result(b, 1'b0);
					in_term = 1'b1;
				end
				ttx_pkg::CLS_HIGH: begin
					if (in_term && held_n == 0) put_result(b, 1'b0);
					else hold_byte(b, 1'b0);
				end
				ttx_pkg::CLS_PUNCT: begin
					if (in_term) begin
						// punct may only follow punct while waiting
						if (held_n == held_punct_n) hold_byte(b, 1'b1);
						else end_term();
					end else begin
						held_n       = 0;
						held_punct_n = 0;
					end
				end
				default: end_term();
			endcase
		end
		last_cls = c;
		if (eos) begin
			end_term();
			last_cls   = ttx_pkg::CLS_OTHER;
			discarding = 1'b0;
		end
		if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		term_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			held_n       = 0;
			held_punct_n = 0;
			last_cls     = ttx_pkg::CLS_OTHER;
			in_term      = 1'b0;
			discarding   = 1'b0;
			errors       = 0;
			awaited      = 0;
		end else begin
			if (s_tvalid && s_tready) predict_terms(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual data=%h sep=%b last=%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = awaited_results.pop_front();
					// the data field carries nothing in a separator
					if (m_tuser !== want.sep || m_tlast !== want.last ||
							(!want.sep && m_tdata !== want.data)) begin
						errors++;
						$display("%0t: result mismatch, expected data=%h sep=%b last=%b, %s",
							$time, want.data, want.sep, want.last,
							$sformatf("actual data=%h sep=%b last=%b",
								m_tdata, m_tuser, m_tlast));
					end
				end
			end
			awaited = awaited_results.size();
		end
	end

endmodule

>>> test/tb_text_term_extractor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_term_extractor_unit
// drives text bytes into the term extractor with random pacing on both sides,
// a directed opening, shaped random text and one long output hold-off
// ----------------------------------------------------------------------------
module tb_text_term_extractor_unit;

	localparam int unsigned RANDOM_BYTES = 360;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned LONG_HOLD    = 300;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	int          errors;
	int          awaited;
	int unsigned cycles = 0;
	int unsigned random_sent;
	bit          pacing;
	bit          hold_request;
	bit          hold_done;

	// {end_of_stream, byte}
	logic [8:0] directed_seq [27] = '{
		9'h061, 9'h021, 9'h062, 9'h080, 9'h0FF, 9'h020, 9'h0C3, 9'h05A, 9'h02E,
		9'h090, 9'h030, 9'h02C, 9'h020, 9'h040, 9'h0A0, 9'h000, 9'h039, 9'h03F,
		9'h07F, 9'h07A, 9'h0E0, 9'h17C, 9'h078, 9'h027, 9'h081, 9'h03D, 9'h1B0
	};
	logic [7:0] punct_set [20] = '{
		8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2C, 8'h2E,
		8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h40, 8'h5C, 8'h5E, 8'h5F, 8'h60, 8'h7C
	};
	logic [7:0] other_set [13] = '{
		8'h22, 8'h28, 8'h29, 8'h2D, 8'h3B, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B,
		8'h7D, 8'h7E, 8'h7F
	};

	text_term_extractor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	text_term_extractor_checker term_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.awaited  (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [7:0] pick_alnum();
		int unsigned r;
		r = $urandom_range(0, 61);
		if (r < 10) return 8'h30 + 8'(r);
		if (r < 36) return 8'h41 + 8'(r - 10);
		return 8'h61 + 8'(r - 36);
	endfunction

	function automatic logic [7:0] pick_high();
		return 8'($urandom_range(128, 255));
	endfunction

	function automatic logic [7:0] pick_punct();
		return punct_set[$urandom_range(0, 19)];
	endfunction

	function automatic logic [7:0] pick_other();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 32));
		return other_set[$urandom_range(0, 12)];
	endfunction

	// one request; called and left at a falling edge, valid stays up between
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = pacing ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		random_sent++;
	endtask

	// words joined by punct and high runs, some joins broken
	task automatic send_text();
		repeat ($urandom_range(1, 5)) begin
			repeat ($urandom_range(1, 6)) send_byte(pick_alnum(), 1'b0);
			case ($urandom_range(0, 5))
				0: begin
					repeat ($urandom_range(1, 3)) send_byte(pick_punct(), 1'b0);
					repeat ($urandom_range(0, 2)) send_byte(pick_high(), 1'b0);
				end
				1: repeat ($urandom_range(1, 4)) send_byte(pick_high(), 1'b0);
				2: begin
					send_byte(pick_punct(), 1'b0);
					send_byte(pick_high(), 1'b0);
					send_byte(pick_punct(), 1'b0);
				end
				3: begin
					send_byte(pick_other(), 1'b0);
					repeat ($urandom_range(1, 4)) send_byte(pick_high(), 1'b0);
				end
				default: send_byte(pick_other(), 1'b0);
			endcase
		end
		send_byte(($urandom_range(0, 1) != 0) ? pick_other() : pick_punct(),
			$urandom_range(0, 3) == 0);
	endtask

	// a long run that may reach or overflow the pending store
	task automatic send_long_run(input int unsigned len, input logic eos);
		if ($urandom_range(0, 1) != 0) begin
			send_byte(pick_alnum(), 1'b0);
			repeat (len) send_byte(pick_punct(), 1'b0);
		end else begin
			send_byte(pick_other(), 1'b0);
			repeat (len) send_byte(pick_high(), 1'b0);
		end
		send_byte(pick_alnum(), eos);
	endtask

	// receiver: random stall after each result, one long hold on request
	initial begin
		int unsigned stall;
		bit          took;
		m_tready = 1'b0;
		stall    = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			took = m_tvalid && m_tready;
			if (hold_request) begin
				hold_request = 1'b0;
				stall        = LONG_HOLD;
			end else if (took) begin
				stall = pacing ? $urandom_range(0, 3) : 0;
			end
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		pacing       = 1'b1;
		hold_request = 1'b0;
		hold_done    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

		random_sent = 0;
		send_long_run(32, 1'b1);
		send_long_run(36, 1'b0);
		while (random_sent < RANDOM_BYTES) begin
			pacing = ($urandom_range(0, 4) != 0);
			if (random_sent >= 120 && !hold_done) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			case ($urandom_range(0, 9))
				6, 7: repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				8: send_long_run($urandom_range(28, 36), $urandom_range(0, 1) != 0);
				default: send_text();
			endcase
		end
		s_tvalid <= 1'b0;

		while (awaited != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
